@@ sv/tcw_pkg.sv @@
// Package for the text console writer: grid sizes, reset values,
// character codes, the action codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Grid geometry. The row count must stay a power of two so the ring
  // offset wraps by plain truncation.
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 32;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int LEN_W    = $clog2(MAX_COLS + 1);
  localparam int LINES_W  = $clog2(MAX_ROWS + 1);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int CHAR_W   = 16;

  // Register reset values.
  localparam logic [LEN_W-1:0]   RESET_LINE_WIDTH    = LEN_W'(54);
  localparam logic [LINES_W-1:0] RESET_VISIBLE_LINES = LINES_W'(25);

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] SPACE_CODE   = CHAR_W'(32);

  // Configuration register indexes.
  localparam logic CFG_LINE_WIDTH    = 1'b0;
  localparam logic CFG_VISIBLE_LINES = 1'b1;

  typedef enum logic [2:0] {
    ACT_PUT       = 3'd0,
    ACT_NEWLINE   = 3'd1,
    ACT_RETURN    = 3'd2,
    ACT_LINEFEED  = 3'd3,
    ACT_BACKSPACE = 3'd4,
    ACT_SET       = 3'd5,
    ACT_CLEAR     = 3'd6,
    ACT_READ      = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUT_SETUP,
    ST_PUT_PAD,
    ST_BS_SHIFT,
    ST_RD_WAIT,
    ST_RESP
  } state_e;

endpackage : tcw_pkg

`default_nettype wire

@@ sv/text_console_writer_top.sv @@
// Top level of the text console writer: sequencer, cell memory,
// line length registers and the configuration registers.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A beat is accepted when start is high and busy is low; its result appears
// for exactly one cycle with done_o high, and the receiver cannot stall it.
// Newline, return, line feed, set cursor, clear, a put of character 10, a
// backspace that shifts nothing and a read past the line's end go from
// EXEC straight to RESP; a read that hits a written cell waits in RD_WAIT;
// a put of any other character passes PUT_SETUP, then PUT_PAD, which pads
// each space in the gap before the cursor and then writes the character;
// a backspace that shifts streams the tail up to the line's end in BS_SHIFT.
// The cell memory has one write port and one registered read port: one
// cell is written per cycle, and the backspace shift streams one read and
// one write per cycle.
// A new beat is taken in the same cycle that the previous result is shown.
// No clearing pass runs after reset; the block is ready at once.
module text_console_writer_top
  import tcw_pkg::*;
(
  input  wire                       clk_i,
  input  wire                       rst_ni,
  // Command channel
  input  wire                       start,
  output logic                      busy,
  input  wire  [2:0]                action_i,
  input  wire  [CHAR_W-1:0]         char_code_i,
  input  wire  [ROW_W-1:0]          row_i,
  input  wire  [COL_W-1:0]          col_i,
  // Result channel
  output logic                      done_o,
  output logic                      ok_o,
  output logic [ROW_W-1:0]          cursor_row_o,
  output logic [LEN_W-1:0]          cursor_col_o,
  output logic [CHAR_W-1:0]         cell_char_o,
  // Configuration write port
  input  wire                       cfg_we_i,
  input  wire                       cfg_idx_i,
  input  wire  [LEN_W-1:0]          cfg_wdata_i
);

  // Control state.
  state_e               state_q, state_d;
  logic [ROW_W-1:0]     top_q, top_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [LEN_W-1:0]     col_q, col_d;
  logic [LEN_W-1:0]     width_q;
  logic [LINES_W-1:0]   lines_q;
  logic [LEN_W-1:0]     len_q [MAX_ROWS];

  // Latched beat and working registers.
  action_e              act_q, act_d;
  logic [CHAR_W-1:0]    char_q, char_d;
  logic [ROW_W-1:0]     rin_q, rin_d;
  logic [COL_W-1:0]     cin_q, cin_d;
  logic                 ok_q, ok_d;
  logic [CHAR_W-1:0]    cell_q, cell_d;
  logic [LEN_W-1:0]     ptr_q, ptr_d;
  logic                 rvld_q, rvld_d;

  // Cell memory ports.
  logic [CHAR_W-1:0]    cell_mem [CELLS];
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [CHAR_W-1:0]    mem_wdata;
  logic [CHAR_W-1:0]    mem_rdata_q;

  // Line length write port.
  logic                 len_we, len_clr;
  logic [ROW_W-1:0]     len_waddr, len_raddr;
  logic [LEN_W-1:0]     len_wdata, len_rd;

  // Derived values.
  logic [LEN_W-1:0]     width_eff;
  logic [LINES_W-1:0]   lines_eff, lines_m1;
  logic [ROW_W-1:0]     cur_pr, rd_pr;
  logic [LINES_W-1:0]   row_inc;
  logic                 lf_scroll;
  logic [ROW_W-1:0]     lf_row, lf_clr_addr;
  logic                 rd_hit, set_bad;
  logic [LEN_W-1:0]     bs_wptr;

  // Clamp the registers into their usable ranges.
  always_comb begin
    if (width_q == '0) begin
      width_eff = LEN_W'(1);
    end else if (width_q > LEN_W'(MAX_COLS)) begin
      width_eff = LEN_W'(MAX_COLS);
    end else begin
      width_eff = width_q;
    end
    if (lines_q == '0) begin
      lines_eff = LINES_W'(1);
    end else if (lines_q > LINES_W'(MAX_ROWS)) begin
      lines_eff = LINES_W'(MAX_ROWS);
    end else begin
      lines_eff = lines_q;
    end
  end

  // Physical rows, line feed arithmetic and range checks.
  assign lines_m1    = lines_eff - LINES_W'(1);
  assign cur_pr      = top_q + row_q;
  assign rd_pr       = top_q + rin_q;
  assign row_inc     = {1'b0, row_q} + LINES_W'(1);
  assign lf_scroll   = (row_inc >= lines_eff);
  assign lf_row      = lf_scroll ? lines_m1[ROW_W-1:0] : row_inc[ROW_W-1:0];
  // New bottom line after a scroll: (top + 1) + (lines - 1).
  assign lf_clr_addr = top_q + lines_eff[ROW_W-1:0];
  assign len_raddr   = (state_q == ST_EXEC && act_q == ACT_READ) ? rd_pr : cur_pr;
  assign len_rd      = len_q[len_raddr];
  assign rd_hit      = ({1'b0, rin_q} < lines_eff) && ({1'b0, cin_q} < len_rd);
  assign set_bad     = ({1'b0, rin_q} >= lines_eff) || ({1'b0, cin_q} >= width_eff);
  assign bs_wptr     = ptr_q - LEN_W'(2);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      ST_IDLE, ST_RESP: begin
        state_d = start ? ST_EXEC : ST_IDLE;
      end
      ST_EXEC: begin
        unique case (act_q)
          ACT_PUT: begin
            state_d = (char_q == NEWLINE_CODE) ? ST_RESP : ST_PUT_SETUP;
          end
          ACT_BACKSPACE: begin
            state_d = (col_q != '0 && col_q < len_rd) ? ST_BS_SHIFT : ST_RESP;
          end
          ACT_READ: begin
            state_d = rd_hit ? ST_RD_WAIT : ST_RESP;
          end
          default: begin
            state_d = ST_RESP;
          end
        endcase
      end
      ST_PUT_SETUP: begin
        state_d = ST_PUT_PAD;
      end
      ST_PUT_PAD: begin
        if (ptr_q >= col_q) state_d = ST_RESP;
      end
      ST_BS_SHIFT: begin
        if (ptr_q >= len_rd) state_d = ST_RESP;
      end
      ST_RD_WAIT: begin
        state_d = ST_RESP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and memory control for each state.
  always_comb begin
    top_d     = top_q;
    row_d     = row_q;
    col_d     = col_q;
    act_d     = act_q;
    char_d    = char_q;
    rin_d     = rin_q;
    cin_d     = cin_q;
    ok_d      = ok_q;
    cell_d    = cell_q;
    ptr_d     = ptr_q;
    rvld_d    = rvld_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {cur_pr, ptr_q[COL_W-1:0]};
    mem_raddr = {cur_pr, ptr_q[COL_W-1:0]};
    mem_wdata = mem_rdata_q;
    len_we    = 1'b0;
    len_clr   = 1'b0;
    len_waddr = cur_pr;
    len_wdata = '0;
    unique case (state_q) inside
      ST_IDLE, ST_RESP: begin
        if (start) begin
          act_d  = action_e'(action_i);
          char_d = char_code_i;
          rin_d  = row_i;
          cin_d  = col_i;
          ok_d   = 1'b1;
          cell_d = '0;
        end
      end
      ST_EXEC: begin
        unique case (act_q) inside
          ACT_PUT, ACT_NEWLINE, ACT_LINEFEED: begin
            // Line feed, newline, character 10 and a put that wraps all run the
            // line feed here; a put that wraps then continues with its write.
            if (act_q == ACT_LINEFEED || act_q == ACT_NEWLINE ||
                char_q == NEWLINE_CODE || col_q >= width_eff) begin
              if (act_q != ACT_LINEFEED) col_d = '0;
              row_d = lf_row;
              if (lf_scroll) begin
                top_d     = top_q + ROW_W'(1);
                len_we    = 1'b1;
                len_waddr = lf_clr_addr;
                len_wdata = '0;
              end
            end
          end
          ACT_RETURN: begin
            col_d = '0;
          end
          ACT_BACKSPACE: begin
            if (col_q != '0) begin
              if (col_q >= len_rd) begin
                col_d = col_q - LEN_W'(1);
                // Deleting the last character only shortens the line.
                if (col_q == len_rd) begin
                  len_we    = 1'b1;
                  len_wdata = len_rd - LEN_W'(1);
                end
              end else begin
                ptr_d  = col_q;
                rvld_d = 1'b0;
              end
            end
          end
          ACT_SET: begin
            if (set_bad) begin
              ok_d = 1'b0;
            end else begin
              row_d = rin_q;
              col_d = {1'b0, cin_q};
            end
          end
          ACT_CLEAR: begin
            len_clr = 1'b1;
            top_d   = '0;
            row_d   = '0;
            col_d   = '0;
          end
          default: begin
            // Cell read: a cell past the line's end or off screen reads as space.
            if (rd_hit) begin
              mem_re    = 1'b1;
              mem_raddr = {rd_pr, cin_q};
            end else begin
              cell_d = SPACE_CODE;
            end
          end
        endcase
      end
      ST_PUT_SETUP: begin
        ptr_d = len_rd;
        if (len_rd <= col_q) begin
          len_we    = 1'b1;
          len_wdata = col_q + LEN_W'(1);
        end
      end
      ST_PUT_PAD: begin
        // Pad the gap with spaces, one cell a cycle, then write the character.
        mem_we = 1'b1;
        if (ptr_q < col_q) begin
          mem_waddr = {cur_pr, ptr_q[COL_W-1:0]};
          mem_wdata = SPACE_CODE;
          ptr_d     = ptr_q + LEN_W'(1);
        end else begin
          mem_waddr = {cur_pr, col_q[COL_W-1:0]};
          mem_wdata = char_q;
          col_d     = col_q + LEN_W'(1);
        end
      end
      ST_BS_SHIFT: begin
        // Stream the tail left: read cell p while cell p-1 read last cycle
        // lands one place to its left. The two addresses never coincide.
        mem_waddr = {cur_pr, bs_wptr[COL_W-1:0]};
        mem_wdata = mem_rdata_q;
        if (ptr_q < len_rd) begin
          mem_re    = 1'b1;
          mem_raddr = {cur_pr, ptr_q[COL_W-1:0]};
          ptr_d     = ptr_q + LEN_W'(1);
          rvld_d    = 1'b1;
          mem_we    = rvld_q;
        end else begin
          mem_we    = 1'b1;
          len_we    = 1'b1;
          len_wdata = len_rd - LEN_W'(1);
          col_d     = col_q - LEN_W'(1);
        end
      end
      ST_RD_WAIT: begin
        cell_d = mem_rdata_q;
      end
      default: begin
      end
    endcase
  end

  // Handshake outputs.
  always_comb begin
    done_o = (state_q == ST_RESP);
    busy   = !(state_q == ST_IDLE || state_q == ST_RESP);
  end

  assign ok_o         = ok_q;
  assign cursor_row_o = row_q;
  assign cursor_col_o = col_q;
  assign cell_char_o  = cell_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      top_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= RESET_LINE_WIDTH;
      lines_q <= RESET_VISIBLE_LINES;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINE_WIDTH:    width_q <= cfg_wdata_i;
        CFG_VISIBLE_LINES: lines_q <= cfg_wdata_i[LINES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Line lengths: one flip-flop row each, cleared all at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ROWS; i++) len_q[i] <= '0;
    end else if (len_clr) begin
      for (int i = 0; i < MAX_ROWS; i++) len_q[i] <= '0;
    end else if (len_we) begin
      len_q[len_waddr] <= len_wdata;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    char_q <= char_d;
    rin_q  <= rin_d;
    cin_q  <= cin_d;
    ok_q   <= ok_d;
    cell_q <= cell_d;
    ptr_q  <= ptr_d;
    rvld_q <= rvld_d;
  end

  // Cell memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= cell_mem[mem_raddr];
  end

endmodule : text_console_writer_top

`default_nettype wire

@@ sv/tcw_checker.sv @@
// Port-level checker for the text console writer and its bind.
// Depends on tcw_pkg and text_console_writer_top.
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker
  import tcw_pkg::*;
(
  input wire              clk_i,
  input wire              rst_ni,
  input wire              start,
  input wire              busy,
  input wire              done_o,
  input wire [LEN_W-1:0]  cursor_col_o
);

  // A result beat is shown only while a new command can be taken.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // An accepted command always occupies the block in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  // Results never come back to back: each command passes EXEC before RESP.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two result beats in a row");

  // Busy only rises right after a command was accepted.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // The cursor column never runs past the widest line.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cursor_col_o <= LEN_W'(MAX_COLS)))
    else $error("cursor column out of range");

endmodule : tcw_checker

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .cursor_col_o (cursor_col_o)
);

`default_nettype wire

@@ tb/sv/text_console_writer_top_tb.sv @@
// Self-checking testbench for text_console_writer_top: a directed table and
// a random command stream, checked against a cycle-free console predictor.
// Depends on tcw_pkg and text_console_writer_top.
`timescale 1ns / 1ps

module text_console_writer_top_tb;
  import tcw_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [ROW_W-1:0]  crow;
    logic [LEN_W-1:0]  ccol;
    logic [CHAR_W-1:0] chr;
  } console_resp_t;

  typedef struct packed {
    action_e           act;
    logic [CHAR_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              has_want;
    console_resp_t     want;
  } console_cmd_t;

  localparam int RANDOM_PHASES    = 10;
  localparam int ITEMS_PER_PHASE  = 85;

  // Clock, reset and block inputs, all known from time zero.
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic [2:0]        action_i = '0;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [ROW_W-1:0]  row_i = '0;
  logic [COL_W-1:0]  col_i = '0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata_i = '0;

  logic              busy;
  logic              done_o;
  logic              ok_o;
  logic [ROW_W-1:0]  cursor_row_o;
  logic [LEN_W-1:0]  cursor_col_o;
  logic [CHAR_W-1:0] cell_char_o;

  // Predictor state: the grid, line lengths, ring offset, cursor, registers.
  logic [CHAR_W-1:0]  mdl_cells [CELLS];
  logic [LEN_W-1:0]   mdl_len [MAX_ROWS];
  logic [ROW_W-1:0]   mdl_top;
  logic [ROW_W-1:0]   mdl_crow;
  logic [LEN_W-1:0]   mdl_ccol;
  logic [LEN_W-1:0]   mdl_width_reg;
  logic [LINES_W-1:0] mdl_lines_reg;

  console_resp_t expected_results [$];
  console_cmd_t  cmd_table [$];
  console_resp_t got_res;
  console_resp_t want_res;

  int failures = 0;
  int results_checked = 0;
  int beats_sent = 0;
  int directed_beats = 0;
  int geometries = 1;
  int act_seen [8];

  int geo_width [RANDOM_PHASES] = '{8, 1, 64, 0, 127, 16, 5, -1, -1, -1};
  int geo_lines [RANDOM_PHASES] = '{4, 1, 32, 0, 63, 127, 3, -1, -1, -1};

  text_console_writer_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .char_code_i  (char_code_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .cell_char_o  (cell_char_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Registers out of range are used clamped.
  function automatic int eff_width();
    if (mdl_width_reg == '0) return 1;
    if (int'(mdl_width_reg) > MAX_COLS) return MAX_COLS;
    return int'(mdl_width_reg);
  endfunction

  function automatic int eff_lines();
    if (mdl_lines_reg == '0) return 1;
    if (int'(mdl_lines_reg) > MAX_ROWS) return MAX_ROWS;
    return int'(mdl_lines_reg);
  endfunction

  function automatic int phys_row(int r);
    return (int'(mdl_top) + r) % MAX_ROWS;
  endfunction

  function automatic void clear_screen();
    foreach (mdl_len[i]) mdl_len[i] = '0;
    mdl_top  = '0;
    mdl_crow = '0;
    mdl_ccol = '0;
  endfunction

  // A line feed on or below the last visible row scrolls and empties the
  // new bottom line.
  function automatic void advance_row();
    int vl;
    vl = eff_lines();
    if (int'(mdl_crow) + 1 >= vl) begin
      mdl_crow = ROW_W'(vl - 1);
      mdl_top  = mdl_top + 1'b1;
      mdl_len[phys_row(vl - 1)] = '0;
    end else begin
      mdl_crow = mdl_crow + 1'b1;
    end
  endfunction

  function automatic void start_new_line();
    mdl_ccol = '0;
    advance_row();
  endfunction

  // Put a character: code 10 is a newline, a full line wraps first, and
  // a gap up to the cursor is padded with spaces.
  function automatic void put_char(logic [CHAR_W-1:0] code);
    int pr;
    int len;
    int cc;
    if (code == NEWLINE_CODE) begin
      start_new_line();
      return;
    end
    if (int'(mdl_ccol) >= eff_width()) start_new_line();
    pr  = phys_row(int'(mdl_crow));
    len = int'(mdl_len[pr]);
    cc  = int'(mdl_ccol);
    if (len <= cc) begin
      for (int i = len; i < cc; i++) mdl_cells[pr * MAX_COLS + i] = SPACE_CODE;
      mdl_len[pr] = LEN_W'(cc + 1);
    end
    mdl_cells[pr * MAX_COLS + cc] = code;
    mdl_ccol = mdl_ccol + 1'b1;
  endfunction

  // Backspace deletes left of the cursor and closes the gap; past the end
  // of the line only the cursor moves, and at column 0 nothing happens.
  function automatic void erase_left();
    int pr;
    int len;
    int cc;
    if (mdl_ccol == '0) return;
    pr  = phys_row(int'(mdl_crow));
    len = int'(mdl_len[pr]);
    cc  = int'(mdl_ccol);
    if (cc <= len) begin
      for (int i = cc; i < len; i++)
        mdl_cells[pr * MAX_COLS + i - 1] = mdl_cells[pr * MAX_COLS + i];
      mdl_len[pr] = LEN_W'(len - 1);
    end
    mdl_ccol = mdl_ccol - 1'b1;
  endfunction

  function automatic console_resp_t console_step(console_cmd_t c);
    console_resp_t r;
    int pr;
    r.ok  = 1'b1;
    r.chr = '0;
    case (c.act)
      ACT_PUT:       put_char(c.code);
      ACT_NEWLINE:   start_new_line();
      ACT_RETURN:    mdl_ccol = '0;
      ACT_LINEFEED:  advance_row();
      ACT_BACKSPACE: erase_left();
      ACT_SET: begin
        if (int'(c.row) >= eff_lines() || int'(c.col) >= eff_width()) begin
          r.ok = 1'b0;
        end else begin
          mdl_crow = c.row;
          mdl_ccol = LEN_W'(c.col);
        end
      end
      ACT_CLEAR:     clear_screen();
      default: begin
        // Rows off screen and cells past the line's length read as space.
        r.chr = SPACE_CODE;
        if (int'(c.row) < eff_lines()) begin
          pr = phys_row(int'(c.row));
          if (int'(c.col) < int'(mdl_len[pr]))
            r.chr = mdl_cells[pr * MAX_COLS + int'(c.col)];
        end
      end
    endcase
    r.crow = mdl_crow;
    r.ccol = mdl_ccol;
    return r;
  endfunction

  function automatic console_cmd_t dir_cmd(action_e a, int code, int r, int c,
                                           bit has_want = 1'b0, int w_ok = 0, int w_row = 0,
                                           int w_col = 0, int w_chr = 0);
    console_cmd_t m;
    m.act       = a;
    m.code      = CHAR_W'(code);
    m.row       = ROW_W'(r);
    m.col       = COL_W'(c);
    m.has_want  = has_want;
    m.want.ok   = w_ok[0];
    m.want.crow = ROW_W'(w_row);
    m.want.ccol = LEN_W'(w_col);
    m.want.chr  = CHAR_W'(w_chr);
    return m;
  endfunction

  // Random command, weighted toward filling lines and reading them back.
  // Cursor moves and reads mostly land inside the current geometry.
  function automatic console_cmd_t random_cmd();
    action_e a;
    int pick;
    int code;
    int r;
    int c;
    pick = $urandom_range(0, 99);
    code = $urandom_range(0, 65535);
    r    = $urandom_range(0, 31);
    c    = $urandom_range(0, 63);
    if (pick < 42) begin
      a = ACT_PUT;
      case ($urandom_range(0, 9))
        0:             code = int'(NEWLINE_CODE);
        1, 2, 3, 4, 5: code = $urandom_range(32, 126);
        default:       ;
      endcase
    end else if (pick < 52) begin
      a = ACT_BACKSPACE;
    end else if (pick < 64) begin
      a = ACT_SET;
      if ($urandom_range(0, 4) != 0) begin
        r = $urandom_range(0, eff_lines() - 1);
        c = $urandom_range(0, eff_width() - 1);
      end
    end else if (pick < 86) begin
      a = ACT_READ;
      if ($urandom_range(0, 4) != 0) begin
        r = $urandom_range(0, eff_lines() - 1);
        c = $urandom_range(0, (eff_width() > 63) ? 63 : eff_width());
      end
    end else if (pick < 91) begin
      a = ACT_NEWLINE;
    end else if (pick < 95) begin
      a = ACT_RETURN;
    end else if (pick < 99) begin
      a = ACT_LINEFEED;
    end else begin
      a = ACT_CLEAR;
    end
    return dir_cmd(a, code, r, c);
  endfunction

  // Present one command beat, hold it until busy is low at an edge, then
  // record what the console should answer.
  task automatic issue_cmd(input console_cmd_t cmd);
    console_resp_t predicted;
    action_i    <= cmd.act;
    char_code_i <= cmd.code;
    row_i       <= cmd.row;
    col_i       <= cmd.col;
    start       <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = console_step(cmd);
    expected_results.push_back(cmd.has_want ? cmd.want : predicted);
    act_seen[int'(cmd.act)]++;
    beats_sent++;
  endtask

  // Wait for the console to drain, then write both registers.
  task automatic settle_and_configure(input int w, input int l);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_LINE_WIDTH;
    cfg_wdata_i <= LEN_W'(w);
    @(posedge clk_i);
    mdl_width_reg = LEN_W'(w);
    cfg_idx_i   <= CFG_VISIBLE_LINES;
    cfg_wdata_i <= LEN_W'(l);
    @(posedge clk_i);
    mdl_lines_reg = LINES_W'(l);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    geometries++;
  endtask

  // Every result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      got_res = '{ok_o, cursor_row_o, cursor_col_o, cell_char_o};
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t ns: unexpected result ok=%0d row=%0d col=%0d char=%h", $time,
                 got_res.ok, got_res.crow, got_res.ccol, got_res.chr);
      end else begin
        want_res = expected_results[0];
        expected_results.delete(0);
        results_checked++;
        if (got_res.ok !== want_res.ok || got_res.crow !== want_res.crow ||
            got_res.ccol !== want_res.ccol || got_res.chr !== want_res.chr) begin
          failures++;
          $display({"%0t ns: mismatch, expected ok=%0d row=%0d col=%0d char=%h, ",
                    "got ok=%0d row=%0d col=%0d char=%h"},
                   $time, want_res.ok, want_res.crow, want_res.ccol, want_res.chr,
                   got_res.ok, got_res.crow, got_res.ccol, got_res.chr);
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then random phases with bursts.
  initial begin
    int w;
    int l;
    int burst_left;
    int gap;
    int drain_cycles;

    clear_screen();
    mdl_width_reg = RESET_LINE_WIDTH;
    mdl_lines_reg = RESET_VISIBLE_LINES;
    foreach (act_seen[i]) act_seen[i] = 0;
    burst_left = 0;
    gap = 0;

    // Directed rows, under the reset geometry of 54 columns and 25 lines.
    cmd_table.push_back(dir_cmd(ACT_READ, 0, 0, 0, 1'b1, 1, 0, 0, int'(SPACE_CODE)));
    cmd_table.push_back(dir_cmd(ACT_PUT, 'h0041, 0, 0, 1'b1, 1, 0, 1, 0));
    cmd_table.push_back(dir_cmd(ACT_PUT, 'hFFFF, 0, 0, 1'b1, 1, 0, 2, 0));
    cmd_table.push_back(dir_cmd(ACT_PUT, 'h0000, 0, 0, 1'b1, 1, 0, 3, 0));
    cmd_table.push_back(dir_cmd(ACT_PUT, int'(NEWLINE_CODE), 0, 0, 1'b1, 1, 1, 0, 0));
    cmd_table.push_back(dir_cmd(ACT_SET, 0, 31, 0, 1'b1, 0, 1, 0, 0));
    cmd_table.push_back(dir_cmd(ACT_SET, 0, 0, 63, 1'b1, 0, 1, 0, 0));
    cmd_table.push_back(dir_cmd(ACT_SET, 0, 24, 53, 1'b1, 1, 24, 53, 0));
    cmd_table.push_back(dir_cmd(ACT_PUT, 'h1234, 0, 0, 1'b1, 1, 24, 54, 0));
    // Wraps on the last row, so the screen scrolls.
    cmd_table.push_back(dir_cmd(ACT_PUT, 'h5678, 0, 0, 1'b1, 1, 24, 1, 0));
    cmd_table.push_back(dir_cmd(ACT_READ, 0, 23, 53));
    cmd_table.push_back(dir_cmd(ACT_SET, 0, 3, 10, 1'b1, 1, 3, 10, 0));
    cmd_table.push_back(dir_cmd(ACT_PUT, 'h0058, 0, 0));
    cmd_table.push_back(dir_cmd(ACT_READ, 0, 3, 5));
    cmd_table.push_back(dir_cmd(ACT_SET, 0, 3, 4));
    cmd_table.push_back(dir_cmd(ACT_BACKSPACE, 0, 0, 0));
    cmd_table.push_back(dir_cmd(ACT_READ, 0, 3, 3));
    cmd_table.push_back(dir_cmd(ACT_RETURN, 0, 0, 0, 1'b1, 1, 3, 0, 0));
    cmd_table.push_back(dir_cmd(ACT_BACKSPACE, 0, 0, 0, 1'b1, 1, 3, 0, 0));
    cmd_table.push_back(dir_cmd(ACT_SET, 0, 3, 30));
    cmd_table.push_back(dir_cmd(ACT_BACKSPACE, 0, 0, 0));
    cmd_table.push_back(dir_cmd(ACT_LINEFEED, 0, 0, 0));
    cmd_table.push_back(dir_cmd(ACT_NEWLINE, 0, 0, 0));
    cmd_table.push_back(dir_cmd(ACT_READ, 0, 31, 63));
    cmd_table.push_back(dir_cmd(ACT_CLEAR, 0, 0, 0, 1'b1, 1, 0, 0, 0));
    cmd_table.push_back(dir_cmd(ACT_READ, 0, 0, 0, 1'b1, 1, 0, 0, int'(SPACE_CODE)));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (cmd_table[i]) issue_cmd(cmd_table[i]);
    directed_beats = beats_sent;

    // Random phases, each under its own geometry; the extremes come first.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      w = (geo_width[p] < 0) ? $urandom_range(1, MAX_COLS) : geo_width[p];
      l = (geo_lines[p] < 0) ? $urandom_range(1, MAX_ROWS) : geo_lines[p];
      settle_and_configure(w, l);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        issue_cmd(random_cmd());
        burst_left--;
        if (burst_left == 0 && gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    // Drain, then allow for the longest backspace shift to finish.
    start <= 1'b0;
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (80) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      failures++;
      $display("%0t ns: %0d expected results never arrived", $time, expected_results.size());
    end

    $display("Sent %0d command beats (%0d directed) across %0d geometries; %0d results checked.",
             beats_sent, directed_beats, geometries, results_checked);
    $display("Mix: %0d puts, %0d backspaces, %0d cursor sets, %0d reads, %0d clears.",
             act_seen[ACT_PUT], act_seen[ACT_BACKSPACE], act_seen[ACT_SET],
             act_seen[ACT_READ], act_seen[ACT_CLEAR]);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard limit on the whole run.
  initial begin
    #(5_000_000);
    $display("%0t ns: run exceeded its time limit", $time);
    $display("TB_ERROR");
    $finish;
  end

endmodule
